// ----- hdl/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the longest-remaining-first scheduler.
// ----------------------------------------------------------------------------
package lrf_pkg;

    localparam int TIME_W      = 12;
    localparam int IDX_OUT_W   = 4;
    localparam int MAX_RESULTS = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = 12'hFFF;

    // queue entry flags, front to back
    typedef struct packed {
        logic store;   // burst goes into the store
        logic last;    // closes the set, starts the schedule
    } t_q_flags;

    // one result; proc_index in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]    turnaround_time;
        logic [TIME_W-1:0]    waiting_time;
        logic [TIME_W-1:0]    completion_time;
        logic [IDX_OUT_W-1:0] proc_index;
    } t_result;

endpackage

// ----- hdl/lrf_front.sv -----
// ----------------------------------------------------------------------------
// lrf_front
// Input side: classifies each burst (store or drop) and queues the stored ones and the last.
// ----------------------------------------------------------------------------
module lrf_front #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] burst
    input  logic                  i_s_axis_tlast,   // last_item
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output lrf_pkg::t_q_flags     o_q_flags,
    output logic [BURST_BITS-1:0] o_q_burst
);
    import lrf_pkg::*;

    localparam int CNTW = $clog2(MAX_PROCS + 1);

    logic [BURST_BITS-1:0] r_q_burst [2];
    t_q_flags              r_q_flags [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_fill;
    logic [CNTW-1:0]       r_fcnt;

    logic accept;
    logic keep;
    logic push;
    logic pop;

    assign o_s_axis_tready = (r_fill != 2'd2);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign keep            = (r_fcnt < CNTW'(MAX_PROCS));
    assign push            = accept && (keep || i_s_axis_tlast);
    assign o_q_valid       = (r_fill != 2'd0);
    assign pop             = o_q_valid && i_q_ready;
    assign o_q_flags       = r_q_flags[r_rp];
    assign o_q_burst       = r_q_burst[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
            r_fcnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
            if (accept) begin
                if (i_s_axis_tlast) begin
                    r_fcnt <= '0;
                end else if (keep) begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_burst[r_wp]       <= BURST_BITS'(i_s_axis_tdata);
            r_q_flags[r_wp].store <= keep;
            r_q_flags[r_wp].last  <= i_s_axis_tlast;
        end
    end

endmodule

// ----- hdl/lrf_engine.sv -----
// ----------------------------------------------------------------------------
// lrf_engine
// Back side: loads the stores, runs the tick loop, emits results.
// ----------------------------------------------------------------------------
module lrf_engine #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_ready,
    input  lrf_pkg::t_q_flags     i_q_flags,
    input  logic [BURST_BITS-1:0] i_q_burst,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output lrf_pkg::t_result      o_res,
    output logic                  o_res_last
);
    import lrf_pkg::*;

    localparam int IW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNTW = $clog2(MAX_PROCS + 1);
    localparam int NW   = (CNTW > 5) ? CNTW : 5;
    localparam int CW   = (BURST_BITS > TIME_W) ? BURST_BITS : TIME_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_TICK,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    // stores
    logic [BURST_BITS-1:0] burst_mem [MAX_PROCS];
    logic [BURST_BITS-1:0] rem_mem   [MAX_PROCS];
    logic [TIME_W-1:0]     comp_mem  [MAX_PROCS];

    t_state                r_state;
    logic [CNTW-1:0]       r_cnt;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_issue_done;
    logic                  r_rd_vld;
    logic [BURST_BITS-1:0] r_best;
    logic [IW-1:0]         r_pick;
    logic [TIME_W-1:0]     r_clk;
    logic [BURST_BITS-1:0] r_rd_rem;
    logic [BURST_BITS-1:0] r_rd_burst;
    logic [TIME_W-1:0]     r_rd_comp;
    logic                  r_ov;
    t_result               r_res;
    logic                  r_res_last;

    logic                  load_store;
    logic                  tick_run;
    logic [IW-1:0]         cnt_idx;
    logic [IW-1:0]         last_idx;
    logic [TIME_W-1:0]     n_clk;
    logic                  rem_we;
    logic [IW-1:0]         rem_wa;
    logic [BURST_BITS-1:0] rem_wd;
    logic                  comp_we;
    logic [IW-1:0]         comp_wa;
    logic [TIME_W-1:0]     comp_wd;
    logic [NW-1:0]         n_res;
    logic                  emit_last;
    logic                  out_free;
    logic [CW-1:0]         c_ext;
    logic [CW-1:0]         b_ext;
    logic [TIME_W-1:0]     calc_wait;
    logic [TIME_W-1:0]     calc_turn;

    assign o_q_ready  = (r_state == S_LOAD);
    assign load_store = o_q_ready && i_q_valid && i_q_flags.store;
    assign tick_run   = (r_state == S_TICK) && (r_best != '0);
    assign cnt_idx    = IW'(r_cnt);
    assign last_idx   = IW'(r_cnt - 1'b1);
    assign n_clk      = (r_clk == TIME_MAX) ? r_clk : r_clk + 12'd1;

    // write port muxing: load or tick, never both
    assign rem_we  = load_store || tick_run;
    assign rem_wa  = tick_run ? r_pick : cnt_idx;
    assign rem_wd  = tick_run ? (r_best - 1'b1) : i_q_burst;
    assign comp_we = (tick_run && (r_best == BURST_BITS'(1)))
                  || (load_store && (i_q_burst == '0));
    assign comp_wa = tick_run ? r_pick : cnt_idx;
    assign comp_wd = tick_run ? n_clk : '0;

    // results
    assign n_res     = (NW'(r_cnt) > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : NW'(r_cnt);
    assign emit_last = ((NW'(r_idx) + NW'(1)) == n_res);
    assign out_free  = !r_ov || i_res_ready;
    assign c_ext     = CW'(r_rd_comp);
    assign b_ext     = CW'(r_rd_burst);
    assign calc_wait = (c_ext > b_ext) ? TIME_W'(c_ext - b_ext) : '0;
    assign calc_turn = (c_ext > b_ext) ? r_rd_comp :
                       (b_ext > CW'(TIME_MAX)) ? TIME_MAX : TIME_W'(b_ext);

    assign o_res_valid = r_ov;
    assign o_res       = r_res;
    assign o_res_last  = r_res_last;

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            rem_mem[rem_wa] <= rem_wd;
        end
        if (load_store) begin
            burst_mem[cnt_idx] <= i_q_burst;
        end
        if (comp_we) begin
            comp_mem[comp_wa] <= comp_wd;
        end
        r_rd_rem   <= rem_mem[r_idx];
        r_rd_burst <= burst_mem[r_idx];
        r_rd_comp  <= comp_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_cmp_idx    <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_best       <= '0;
            r_pick       <= '0;
            r_clk        <= '0;
            r_ov         <= 1'b0;
            r_res_last   <= 1'b0;
        end else begin
            if (i_res_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_q_valid) begin
                        if (i_q_flags.store) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_q_flags.last) begin
                            r_state      <= S_SCAN;
                            r_idx        <= '0;
                            r_issue_done <= 1'b0;
                            r_rd_vld     <= 1'b0;
                            r_best       <= '0;
                            r_pick       <= '0;
                            r_clk        <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_issue_done) begin
                        r_idx     <= r_idx + 1'b1;
                        r_cmp_idx <= r_idx;
                        r_rd_vld  <= 1'b1;
                        if (r_idx == last_idx) begin
                            r_issue_done <= 1'b1;
                        end
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        // strict compare keeps the lowest index on ties
                        if (r_rd_rem > r_best) begin
                            r_best <= r_rd_rem;
                            r_pick <= r_cmp_idx;
                        end
                        if (r_cmp_idx == last_idx) begin
                            r_state <= S_TICK;
                        end
                    end
                end
                S_TICK: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_rd_vld     <= 1'b0;
                    r_best       <= '0;
                    r_pick       <= '0;
                    if (r_best == '0) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_clk   <= n_clk;
                        r_state <= S_SCAN;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_res_last <= emit_last;
                        if (emit_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_res.proc_index      <= IDX_OUT_W'(r_idx);
            r_res.completion_time <= r_rd_comp;
            r_res.waiting_time    <= calc_wait;
            r_res.turnaround_time <= calc_turn;
        end
    end

endmodule

// ----- hdl/longest_remaining_first_sched_top.sv -----
// ----------------------------------------------------------------------------
// longest_remaining_first_sched_top
// Preemptive longest-remaining-first scheduler for up to MAX_PROCS processes.
// ----------------------------------------------------------------------------
// Timing: bursts are taken one per cycle into a two-entry queue while it is not
// full; after the last item each unit tick runs a serial scan of the
// remaining-time store over the N processes in the set, plus one closing scan.
// Each result then passes a store-read state and an emit state in turn, and waits while the output register is held.
// Throughput: one set at a time; input stalls once the queue is full.
// Reset: synchronous, active low; clears control only, stores are not cleared.
module longest_remaining_first_sched_top #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] burst
    input  logic        i_s_axis_tlast,   // last_item
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [3:0] proc_index, [15:4] completion_time,
                                          // [27:16] waiting_time, [39:28] turnaround_time
    output logic        o_m_axis_tlast    // last_result
);
    import lrf_pkg::*;

    // queue between front and back
    logic                  q_valid;
    logic                  q_ready;
    t_q_flags              q_flags;
    logic [BURST_BITS-1:0] q_burst;
    t_result               res;

    // front: classify each transfer as store/drop, queue the stored ones and the last
    lrf_front #(
        .MAX_PROCS  (MAX_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_valid       (q_valid),
        .i_q_ready       (q_ready),
        .o_q_flags       (q_flags),
        .o_q_burst       (q_burst)
    );

    // back: store load, tick loop, result emission through an output register
    lrf_engine #(
        .MAX_PROCS  (MAX_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_flags   (q_flags),
        .i_q_burst   (q_burst),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res),
        .o_res_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = res;

endmodule

// ----- hdl/lrf_checker.sv -----
// ----------------------------------------------------------------------------
// lrf_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
module lrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    logic [3:0] r_exp_idx;
    logic       out_xfer;

    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= 4'd0;
        end else if (out_xfer) begin
            r_exp_idx <= o_m_axis_tlast ? 4'd0 : r_exp_idx + 4'd1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // results of a set come in index order from zero
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> o_m_axis_tdata[3:0] == r_exp_idx)
        else $error("result index out of order");

    // waiting never exceeds completion
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[27:16] <= o_m_axis_tdata[15:4])
        else $error("waiting above completion");

    // a process that waited finished at its turnaround time
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[27:16] != 12'd0) |->
            o_m_axis_tdata[39:28] == o_m_axis_tdata[15:4])
        else $error("turnaround differs from completion");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind longest_remaining_first_sched_top lrf_checker u_lrf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
